### src/assert_macros.svh
// Assertion macros used by the list unit's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("list unit assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("list unit assertion failed");

`endif

### src/pida_pkg.sv
// Types and constants of the positional insert/delete list unit.
package pida_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int OIDX_W = 6;
  localparam int CAP_W  = 7;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BADPOS = 2'd2,
    STS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    pos_t     pos;
    idx_t     tail;
    data_t    value;
  } cell_cmd_t;

endpackage

### src/positional_insert_delete_array_unit.sv
// Top level of the positional insert/delete list: control, cell chain and output register.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tuser: mode; tdata: position, value_in
//  out_    | master    | out_tvalid/tready  | tuser: status; tdata: value_out, index_out; tlast
//  cfg_    | write     | cfg_we             | cfg_wdata: capacity
//
// Insert and delete finish in the cycle they are accepted: all affected cells shift at once.
// A dump of n entries gives one beat per cycle while the output is not stalled, by rotating
// the first n cells past cell 0; no new item is taken until the last dump beat is registered.
// Reset (rst_n low, synchronous) clears count and control and sets capacity to DEPTH; entries are not cleared.
// A stalled output holds its beat; the dump waits on out_tready between beats.
`include "assert_macros.svh"

module positional_insert_delete_array_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic [39:0] in_tdata,   // [6:0] position, [38:7] value_in, [39] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [39:0] out_tdata,  // [31:0] value_out, [37:32] index_out, [39:38] zero
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata   // [6:0] capacity
);
  import pida_pkg::*;

  // Control and configuration registers
  state_t            state_r, state_nxt;
  cnt_t              count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  idx_t              dump_idx_r, dump_idx_nxt;
  idx_t              dump_tail_r, dump_tail_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  data_t             out_value_r, out_value_nxt;
  logic [OIDX_W-1:0] out_index_r, out_index_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t         cmd;
  data_t             cell_q [DEPTH];

  logic              accept;
  logic              out_free;
  mode_t             mode;
  pos_t              pos;
  data_t             value_in;
  cnt_t              cap_eff;
  logic              ins_full;
  logic              ins_bad;
  logic              del_bad;

  assign mode     = mode_t'(in_tuser);
  assign pos      = in_tdata[POS_W-1:0];
  assign value_in = in_tdata[POS_W+DATA_W-1:POS_W];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Saturate capacity at the chain length
  assign cap_eff  = (CNT_W'(cap_r) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign ins_full = count_r >= cap_eff;
  assign ins_bad  = pos > POS_W'(count_r);
  assign del_bad  = pos >= POS_W'(count_r);

  // Decode the item, steer the cells and fill the output register
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    dump_tail_nxt  = dump_tail_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    cmd.op         = OP_HOLD;
    cmd.pos        = pos;
    cmd.tail       = dump_tail_r;
    cmd.value      = value_in;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_INSERT: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_index_nxt = '0;
              out_last_nxt  = 1'b1;
              if (ins_full) begin
                out_status_nxt = STS_FULL;
              end else if (ins_bad) begin
                out_status_nxt = STS_BADPOS;
              end else begin
                out_status_nxt = STS_OK;
                cmd.op         = OP_INSERT;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            MODE_DELETE: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_index_nxt = '0;
              out_last_nxt  = 1'b1;
              if (del_bad) begin
                out_status_nxt = STS_BADPOS;
              end else begin
                out_status_nxt = STS_OK;
                cmd.op         = OP_DELETE;
                count_nxt      = count_r - CNT_W'(1);
              end
            end
            MODE_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_EMPTY;
                out_value_nxt  = '0;
                out_index_nxt  = '0;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt     = S_DUMP;
                dump_idx_nxt  = '0;
                dump_tail_nxt = IDX_W'(count_r - CNT_W'(1));
              end
            end
            default: begin
              // drop the unused mode
            end
          endcase
        end
      end
      S_DUMP: begin
        // Emit cell 0 and rotate the valid part of the chain by one
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_value_nxt  = cell_q[0];
          out_index_nxt  = OIDX_W'(dump_idx_r);
          out_last_nxt   = (dump_idx_r == dump_tail_r);
          cmd.op         = OP_ROTATE;
          dump_idx_nxt   = dump_idx_r + IDX_W'(1);
          if (dump_idx_r == dump_tail_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    dump_idx_r   <= dump_idx_nxt;
    dump_tail_r  <= dump_tail_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Row of cells, each wired to its neighbors and to the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_d;
    data_t right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[i+1];
    end
    pida_cell u_cell (
      .clk     (clk),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .left_i  (left_d),
      .right_i (right_d),
      .head_i  (cell_q[0]),
      .data_o  (cell_q[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_index_r, out_value_r};
  assign out_tlast  = out_last_r;

  // Checks on the list control
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(a_dump_idx, clk, rst_n, state_r == S_DUMP, dump_idx_r <= dump_tail_r)
  `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `ASSERT_NEXT(a_ins_count, clk, rst_n, accept && mode == MODE_INSERT && !ins_full && !ins_bad, count_r == $past(count_r) + CNT_W'(1))

endmodule

### src/pida_cell.sv
// One storage cell of the list chain: holds an entry, takes a neighbor's on a shift.
module pida_cell (
  input  logic              clk,
  input  pida_pkg::idx_t    idx_i,
  input  pida_pkg::cell_cmd_t cmd_i,
  input  pida_pkg::data_t   left_i,
  input  pida_pkg::data_t   right_i,
  input  pida_pkg::data_t   head_i,
  output pida_pkg::data_t   data_o
);
  import pida_pkg::*;

  data_t data_r;
  data_t data_nxt;
  pos_t  my_pos;

  assign my_pos = POS_W'(idx_i);

  // Pick the next entry from the command and this cell's place in the row.
  always_comb begin
    data_nxt = data_r;
    case (cmd_i.op)
      OP_INSERT: begin
        if (my_pos == cmd_i.pos) begin
          data_nxt = cmd_i.value;
        end else if (my_pos > cmd_i.pos) begin
          data_nxt = left_i;
        end
      end
      OP_DELETE: begin
        if (my_pos >= cmd_i.pos) begin
          data_nxt = right_i;
        end
      end
      OP_ROTATE: begin
        if (idx_i == cmd_i.tail) begin
          data_nxt = head_i;
        end else if (idx_i < cmd_i.tail) begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
